@@ rtl/core/stl_pkg.sv @@
// ----------------------------------------------------------------------------
// stl_pkg: shared types and constants of the script token lexer
// Token kinds, lexer modes, the lexer state record and the keyword table.
// ----------------------------------------------------------------------------
package stl_pkg;

	// Offsets are accepted below this value (smaller of buffer size and 65535)
	localparam int unsigned BufferBytes = 65536;
	localparam logic [15:0] POS_LIMIT   = (BufferBytes < 65535) ?
		16'(BufferBytes) : 16'd65535;

	// Most tokens one byte can release
	localparam int unsigned MAX_TOKENS = 3;
	localparam int unsigned CNT_W      = $clog2(MAX_TOKENS + 1);

	typedef enum logic [4:0] {
		K_INVALID = 5'd0,
		K_ORG     = 5'd1,
		K_HEX     = 5'd2,
		K_LPAREN  = 5'd3,
		K_RPAREN  = 5'd4,
		K_IDENT   = 5'd5,
		K_INIT    = 5'd6,
		K_TEXT    = 5'd7,
		K_LINE    = 5'd8,
		K_PARA    = 5'd9,
		K_CONT    = 5'd10,
		K_DONE    = 5'd11,
		K_COLON   = 5'd12,
		K_COMMA   = 5'd13,
		K_SEMI    = 5'd14,
		K_STRING  = 5'd15,
		K_END     = 5'd16
	} kind_t;

	typedef enum logic [2:0] {
		MODE_IDLE    = 3'd0,
		MODE_COMMENT = 3'd1,
		MODE_ORG     = 3'd2,
		MODE_HEX     = 3'd3,
		MODE_IDENT   = 3'd4,
		MODE_STRING  = 3'd5
	} mode_t;

	typedef struct packed {
		mode_t       mode;
		logic [15:0] pos;
		logic [15:0] pstart;
		logic [15:0] plen;
		logic [31:0] fchars;
		logic        err;
	} lex_state_t;

	localparam lex_state_t STATE_RESET = '{
		mode:   MODE_IDLE,
		pos:    16'd0,
		pstart: 16'd0,
		plen:   16'd0,
		fchars: 32'd0,
		err:    1'b0
	};

	typedef struct packed {
		kind_t       kind;
		logic [15:0] start;
		logic [15:0] length;
		logic        last;
	} token_t;

	// Keywords packed first character in the top byte
	localparam logic [31:0] KW_WORDS [6] = '{
		32'h696E_6974, // init
		32'h7465_7874, // text
		32'h6C69_6E65, // line
		32'h7061_7261, // para
		32'h636F_6E74, // cont
		32'h646F_6E65  // done
	};

endpackage

@@ rtl/core/stl_if.sv @@
// ----------------------------------------------------------------------------
// stl_in_if / stl_tok_if: valid/ready channels of the script token lexer
// Byte input channel and token output channel.
// ----------------------------------------------------------------------------
interface stl_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_input;

	modport source (output valid, output data_byte, output end_of_input, input ready);
	modport sink   (input valid, input data_byte, input end_of_input, output ready);
endinterface

interface stl_tok_if;
	logic        valid;
	logic        ready;
	logic [4:0]  token_kind;
	logic [15:0] token_start;
	logic [15:0] token_length;
	logic        last;

	modport source (output valid, output token_kind, output token_start,
		output token_length, output last, input ready);
	modport sink   (input valid, input token_kind, input token_start,
		input token_length, input last, output ready);
endinterface

@@ rtl/core/stl_step.sv @@
// ----------------------------------------------------------------------------
// stl_step: next-state and token logic for one script byte
// Pure combinational; gives the next lexer state and up to three tokens.
// ----------------------------------------------------------------------------
module stl_step (
	input  stl_pkg::lex_state_t                          state,
	input  logic [7:0]                                   data_byte,
	input  logic                                         end_of_input,
	output stl_pkg::lex_state_t                          next_state,
	output stl_pkg::token_t [stl_pkg::MAX_TOKENS-1:0]    toks,
	output logic [stl_pkg::CNT_W-1:0]                    tok_cnt
);
	import stl_pkg::*;

	localparam int unsigned NCAND = 4;

	function automatic token_t mk_tok(kind_t k, logic [15:0] s, logic [15:0] l, logic lst);
		token_t t;
		t.kind   = k;
		t.start  = s;
		t.length = l;
		t.last   = lst;
		return t;
	endfunction

	function automatic kind_t ident_kind(logic [31:0] fc, logic [15:0] len);
		kind_t k;
		k = K_IDENT;
		if (len == 16'd4) begin
			if (fc == KW_WORDS[0]) k = K_INIT;
			if (fc == KW_WORDS[1]) k = K_TEXT;
			if (fc == KW_WORDS[2]) k = K_LINE;
			if (fc == KW_WORDS[3]) k = K_PARA;
			if (fc == KW_WORDS[4]) k = K_CONT;
			if (fc == KW_WORDS[5]) k = K_DONE;
		end
		return k;
	endfunction

	logic        room;
	logic [15:0] p;
	logic        is_hex, is_head, is_body, is_eol;
	logic        do_bt;
	logic [7:0]  org_ch;
	logic [15:0] plen_inc;
	token_t      cand [NCAND];
	logic        cv   [NCAND];
	lex_state_t  nx;
	logic [CNT_W-1:0] cnt;

	assign room     = state.pos < POS_LIMIT;
	assign p        = state.pos;
	assign plen_inc = state.plen + 16'd1;
	assign is_hex   = data_byte inside {[8'h30:8'h39], [8'h61:8'h66], [8'h41:8'h46]};
	assign is_head  = data_byte inside {[8'h41:8'h5A], [8'h61:8'h7A], 8'h5F};
	assign is_body  = is_head || (data_byte inside {[8'h30:8'h39]});
	assign is_eol   = (data_byte == 8'h0D) || (data_byte == 8'h0A);

	// expected character after '@' for the current pending length
	always_comb begin
		case (state.plen)
			16'd1:   org_ch = 8'h6F; // o
			16'd2:   org_ch = 8'h72; // r
			16'd3:   org_ch = 8'h67; // g
			default: org_ch = 8'h00;
		endcase
	end

	always_comb begin
		nx    = state;
		do_bt = 1'b0;
		for (int i = 0; i < NCAND; i++) begin
			cand[i] = '0;
			cv[i]   = 1'b0;
		end

		// feed the byte to the current mode
		if (!state.err) begin
			if (!room) begin
				cand[0] = mk_tok(K_INVALID, state.pos, 16'd0, 1'b0);
				cv[0]   = 1'b1;
				nx.err  = 1'b1;
				nx.mode = MODE_IDLE;
			end else begin
				nx.pos = state.pos + 16'd1;
				case (state.mode)
					MODE_COMMENT: begin
						if (is_eol)
							nx.mode = MODE_IDLE;
					end
					MODE_ORG: begin
						if (state.plen >= 16'd1 && state.plen <= 16'd3 && data_byte == org_ch) begin
							nx.plen = plen_inc;
							if (plen_inc == 16'd4) begin
								cand[0] = mk_tok(K_ORG, state.pstart, 16'd4, 1'b0);
								cv[0]   = 1'b1;
								nx.mode = MODE_IDLE;
							end
						end else begin
							cand[0] = mk_tok(K_INVALID, state.pstart, 16'd0, 1'b0);
							cv[0]   = 1'b1;
							nx.err  = 1'b1;
							nx.mode = MODE_IDLE;
						end
					end
					MODE_HEX: begin
						if (is_hex) begin
							nx.plen = plen_inc;
						end else if (state.plen < 16'd2) begin
							cand[0] = mk_tok(K_INVALID, state.pstart, 16'd0, 1'b0);
							cv[0]   = 1'b1;
							nx.err  = 1'b1;
							nx.mode = MODE_IDLE;
						end else begin
							cand[0] = mk_tok(K_HEX, state.pstart, state.plen, 1'b0);
							cv[0]   = 1'b1;
							do_bt   = 1'b1;
						end
					end
					MODE_IDENT: begin
						if (is_body) begin
							nx.plen = plen_inc;
							if (plen_inc <= 16'd4)
								nx.fchars = {state.fchars[23:0], data_byte};
						end else begin
							cand[0] = mk_tok(ident_kind(state.fchars, state.plen),
								state.pstart, state.plen, 1'b0);
							cv[0]   = 1'b1;
							do_bt   = 1'b1;
						end
					end
					MODE_STRING: begin
						nx.plen = plen_inc;
						if (data_byte == 8'h22) begin
							cand[0] = mk_tok(K_STRING, state.pstart, plen_inc, 1'b0);
							cv[0]   = 1'b1;
							nx.mode = MODE_IDLE;
						end
					end
					default: do_bt = 1'b1;
				endcase
			end
		end else if (room) begin
			nx.pos = state.pos + 16'd1;
		end

		// open a token with this byte
		if (do_bt) begin
			nx.mode = MODE_IDLE;
			case (data_byte)
				8'h20, 8'h09, 8'h0D, 8'h0A: ;
				8'h23: nx.mode = MODE_COMMENT;
				8'h40, 8'h24, 8'h22: begin
					nx.mode   = (data_byte == 8'h40) ? MODE_ORG :
						(data_byte == 8'h24) ? MODE_HEX : MODE_STRING;
					nx.pstart = p;
					nx.plen   = 16'd1;
				end
				8'h28: begin cand[1] = mk_tok(K_LPAREN, p, 16'd1, 1'b0); cv[1] = 1'b1; end
				8'h29: begin cand[1] = mk_tok(K_RPAREN, p, 16'd1, 1'b0); cv[1] = 1'b1; end
				8'h3A: begin cand[1] = mk_tok(K_COLON,  p, 16'd1, 1'b0); cv[1] = 1'b1; end
				8'h2C: begin cand[1] = mk_tok(K_COMMA,  p, 16'd1, 1'b0); cv[1] = 1'b1; end
				8'h3B: begin cand[1] = mk_tok(K_SEMI,   p, 16'd1, 1'b0); cv[1] = 1'b1; end
				default: begin
					if (is_head) begin
						nx.mode   = MODE_IDENT;
						nx.pstart = p;
						nx.plen   = 16'd1;
						nx.fchars = {24'd0, data_byte};
					end else begin
						cand[1] = mk_tok(K_INVALID, p, 16'd0, 1'b0);
						cv[1]   = 1'b1;
						nx.err  = 1'b1;
					end
				end
			endcase
		end

		// final byte: close any pending token, then mark the end
		if (end_of_input) begin
			if (!nx.err) begin
				case (nx.mode)
					MODE_ORG, MODE_STRING: begin
						cand[2] = mk_tok(K_INVALID, nx.pstart, 16'd0, 1'b0);
						cv[2]   = 1'b1;
					end
					MODE_HEX: begin
						cv[2] = 1'b1;
						if (nx.plen < 16'd2)
							cand[2] = mk_tok(K_INVALID, nx.pstart, 16'd0, 1'b0);
						else
							cand[2] = mk_tok(K_HEX, nx.pstart, nx.plen, 1'b0);
					end
					MODE_IDENT: begin
						cand[2] = mk_tok(ident_kind(nx.fchars, nx.plen),
							nx.pstart, nx.plen, 1'b0);
						cv[2]   = 1'b1;
					end
					default: ;
				endcase
			end
			cand[3] = mk_tok(K_END, nx.pos, 16'd0, 1'b1);
			cv[3]   = 1'b1;
			nx      = STATE_RESET;
		end
	end

	// pack the raised tokens in order
	always_comb begin
		cnt  = '0;
		toks = '0;
		for (int i = 0; i < NCAND; i++) begin
			if (cv[i] && cnt != CNT_W'(MAX_TOKENS)) begin
				toks[cnt[1:0]] = cand[i];
				cnt            = cnt + CNT_W'(1);
			end
		end
	end

	assign next_state = nx;
	assign tok_cnt    = cnt;

endmodule

@@ rtl/core/script_token_lexer_core.sv @@
// ----------------------------------------------------------------------------
// script_token_lexer_core: byte-stream lexer for the script language
// Splits a script into tokens (kind, start offset, length), one byte a cycle while the token output keeps up.
// ----------------------------------------------------------------------------
// Output: the first token a byte releases is offered in the cycle after the
//   byte's transaction; further tokens from it follow one a cycle while ready.
// Input: one byte per cycle while each byte releases at most one token and
//   the output is ready; a byte that releases more tokens holds the input
//   until the single-token output port has drained the token buffer.
// Reset: arst_n clears the lexer state and empties the token buffer.
// ----------------------------------------------------------------------------
module script_token_lexer_core (
	input  logic          clk,
	input  logic          arst_n,
	stl_in_if.sink        script,
	stl_tok_if.source     tokens
);
	import stl_pkg::*;

	lex_state_t                  state_q;
	lex_state_t                  state_nx;
	token_t [MAX_TOKENS-1:0]     step_toks;
	logic   [CNT_W-1:0]          step_cnt;

	// Token buffer: slot 0 is on the output port, the rest queue behind it
	token_t [MAX_TOKENS-1:0]     tok_q;
	logic   [CNT_W-1:0]          cnt_q;

	logic in_take;
	logic out_take;

	// One pass of the lexer on the byte at the port
	stl_step u_step (
		.state        (state_q),
		.data_byte    (script.data_byte),
		.end_of_input (script.end_of_input),
		.next_state   (state_nx),
		.toks         (step_toks),
		.tok_cnt      (step_cnt)
	);

	assign out_take = tokens.valid && tokens.ready;

	// Take a new byte once the buffer is empty, or is emptied by this cycle's
	// output transaction; the buffer is then overwritten with the new tokens.
	assign script.ready = (cnt_q == '0) ||
		((cnt_q == CNT_W'(1)) && tokens.ready);
	assign in_take = script.valid && script.ready;

	// Advance the lexer state on every input transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (in_take) begin
			state_q <= state_nx;
		end
	end

	// Buffer occupancy: load on input, count down on output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (in_take) begin
			cnt_q <= step_cnt;
		end else if (out_take) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	// Token payload: load the new tokens, or shift the queue toward slot 0
	always_ff @(posedge clk) begin
		if (in_take) begin
			tok_q <= step_toks;
		end else if (out_take) begin
			for (int i = 0; i < MAX_TOKENS - 1; i++)
				tok_q[i] <= tok_q[i+1];
		end
	end

	assign tokens.valid        = (cnt_q != '0);
	assign tokens.token_kind   = tok_q[0].kind;
	assign tokens.token_start  = tok_q[0].start;
	assign tokens.token_length = tok_q[0].length;
	assign tokens.last         = tok_q[0].last;

endmodule
